[hdl/lpsf_pkg.sv]
// ----------------------------------------------------------------------------
// lpsf_pkg
// Types, codes and frame constants shared by the link primary station logic.
// ----------------------------------------------------------------------------
package lpsf_pkg;

   // Link states, one-hot
   typedef enum logic [7:0] {
      ST_UNRESET_IDLE   = 8'b0000_0001,
      ST_RESET_IDLE     = 8'b0000_0010,
      ST_RL_WAIT        = 8'b0000_0100,
      ST_RL_WAIT_DATA   = 8'b0000_1000,
      ST_UR_STATUS_WAIT = 8'b0001_0000,
      ST_R_STATUS_WAIT  = 8'b0010_0000,
      ST_TEST_WAIT      = 8'b0100_0000,
      ST_CFM_WAIT       = 8'b1000_0000
   } lpsf_state_type;

   // Link state codes as seen on the result word
   localparam logic [2:0] CODE_UNRESET_IDLE   = 3'd0;
   localparam logic [2:0] CODE_RESET_IDLE     = 3'd1;
   localparam logic [2:0] CODE_RL_WAIT        = 3'd2;
   localparam logic [2:0] CODE_RL_WAIT_DATA   = 3'd3;
   localparam logic [2:0] CODE_UR_STATUS_WAIT = 3'd4;
   localparam logic [2:0] CODE_R_STATUS_WAIT  = 3'd5;
   localparam logic [2:0] CODE_TEST_WAIT      = 3'd6;
   localparam logic [2:0] CODE_CFM_WAIT       = 3'd7;

   typedef enum logic [2:0] {
      OP_SEND_UNCONF = 3'd0,
      OP_SEND_CONF   = 3'd1,
      OP_SEND_TEST   = 3'd2,
      OP_TIMEOUT     = 3'd3,
      OP_FRAME_RX    = 3'd4
   } lpsf_op_type;

   typedef enum logic [1:0] {
      TMR_KEEP  = 2'd0,
      TMR_START = 2'd1,
      TMR_STOP  = 2'd2
   } lpsf_timer_type;

   localparam logic [3:0] FC_ACK         = 4'd0;
   localparam logic [3:0] FC_NACK        = 4'd1;
   localparam logic [3:0] FC_CFM_DATA    = 4'd3;
   localparam logic [3:0] FC_UNCONF_DATA = 4'd4;
   localparam logic [3:0] FC_LINK_STATUS = 4'd11;

   localparam logic [7:0] CTRL_RESET_LINK  = 8'hC0;
   localparam logic [7:0] CTRL_STATUS_REQ  = 8'hC9;
   localparam logic [7:0] CTRL_UNCONF_DATA = 8'hC4;
   localparam logic [7:0] CTRL_ACK         = 8'h80;
   localparam logic [7:0] CTRL_FCV_BASE    = 8'hD0;
   localparam logic [7:0] CTRL_FC_TEST     = 8'h02;
   localparam logic [7:0] CTRL_FC_CFM      = 8'h03;

   localparam logic [7:0] HDR_LENGTH        = 8'd5;
   localparam logic [7:0] MAX_USER_LENGTH   = 8'd250;
   localparam logic [3:0] RETRY_LIMIT_RESET = 4'd3;

   typedef struct packed {
      logic [2:0] operation;
      logic       rx_primary;
      logic [3:0] rx_function;
      logic       rx_dfc;
      logic [7:0] user_length;
   } lpsf_item_type;

   typedef struct packed {
      logic       accepted;
      logic       send_valid;
      logic [7:0] send_control;
      logic [7:0] send_length;
      logic       attach_userdata;
      logic       deliver_userdata;
      logic [1:0] timer_command;
      logic [2:0] link_state_out;
      logic       station_reset_out;
      logic       station_overflow_out;
   } lpsf_result_type;

   function automatic logic [2:0] state_code(input lpsf_state_type st);
      logic [2:0] code;
      unique case (st)
         ST_UNRESET_IDLE:   code = CODE_UNRESET_IDLE;
         ST_RESET_IDLE:     code = CODE_RESET_IDLE;
         ST_RL_WAIT:        code = CODE_RL_WAIT;
         ST_RL_WAIT_DATA:   code = CODE_RL_WAIT_DATA;
         ST_UR_STATUS_WAIT: code = CODE_UR_STATUS_WAIT;
         ST_R_STATUS_WAIT:  code = CODE_R_STATUS_WAIT;
         ST_TEST_WAIT:      code = CODE_TEST_WAIT;
         ST_CFM_WAIT:       code = CODE_CFM_WAIT;
         default:           code = CODE_UNRESET_IDLE;
      endcase
      return code;
   endfunction

   // Control byte with frame count valid set and the given FCB
   function automatic logic [7:0] fcv_control(input logic fcb, input logic [7:0] fc);
      return CTRL_FCV_BASE | {2'b00, fcb, 5'b0_0000} | fc;
   endfunction

endpackage

[hdl/lpsf_if.sv]
// ----------------------------------------------------------------------------
// lpsf_if
// Request, response and register write channels of the link primary station.
// ----------------------------------------------------------------------------
interface lpsf_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] operation;
   logic       rx_primary;
   logic [3:0] rx_function;
   logic       rx_dfc;
   logic [7:0] user_length;

   modport source (output valid, operation, rx_primary, rx_function, rx_dfc,
                   user_length, input ready);
   modport sink   (input valid, operation, rx_primary, rx_function, rx_dfc,
                   user_length, output ready);
endinterface

interface lpsf_rsp_if;
   logic       valid;
   logic       ready;
   logic       accepted;
   logic       send_valid;
   logic [7:0] send_control;
   logic [7:0] send_length;
   logic       attach_userdata;
   logic       deliver_userdata;
   logic [1:0] timer_command;
   logic [2:0] link_state_out;
   logic       station_reset_out;
   logic       station_overflow_out;

   modport source (output valid, accepted, send_valid, send_control, send_length,
                   attach_userdata, deliver_userdata, timer_command,
                   link_state_out, station_reset_out, station_overflow_out,
                   input ready);
   modport sink   (input valid, accepted, send_valid, send_control, send_length,
                   attach_userdata, deliver_userdata, timer_command,
                   link_state_out, station_reset_out, station_overflow_out,
                   output ready);
endinterface

interface lpsf_csr_if;
   logic       valid;
   logic       ready;
   logic [3:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

[hdl/link_primary_station_fsm.sv]
// ----------------------------------------------------------------------------
// link_primary_station_fsm
// Primary-side data link state machine: one event word in, one result word out.
// ----------------------------------------------------------------------------
// Usage
//   req_bus : event words (send unconfirmed, send confirmed, send test,
//             response timeout, received header). Taken when valid && ready.
//   rsp_bus : one result word per event: frame control and length bytes,
//             user data attach/deliver flags, timer command and link status.
//   csr_bus : write of retry_limit (4 bits, reset 3). Always ready; write it
//             only while no event is in flight.
//   Path    : a word taken from req_bus sits in the input register, then loads
//             the result register.
//   Rate    : one word per cycle while rsp_bus.ready is high. The decision is a
//             single combinational pass over the input register and the link
//             state; state commits on the same edge that loads the result
//             register, so the next word already sees it.
//   Stall   : while rsp_bus.ready is low the result register holds; the input
//             register still takes one more word, then req_bus.ready drops.
//   Reset   : synchronous; link goes to unreset idle, counters and flags
//             clear, both pipeline registers empty, retry_limit back to 3.
// ----------------------------------------------------------------------------
module link_primary_station_fsm (
   input  logic              clock,
   input  logic              reset,
   lpsf_req_if.sink          req_bus,
   lpsf_rsp_if.source        rsp_bus,
   lpsf_csr_if.sink          csr_bus
);
   import lpsf_pkg::*;

   // Pipeline registers
   logic            in_valid_ff;
   lpsf_item_type   in_item_ff;
   logic            out_valid_ff;
   lpsf_result_type out_ff;
   lpsf_result_type out_in;

   // Link state
   lpsf_state_type  state_ff,   state_in;
   logic [3:0]      retry_ff,   retry_in;
   logic            fcb_ff,     fcb_in;
   logic            sreset_ff,  sreset_in;
   logic            sovf_ff,    sovf_in;
   logic [7:0]      plen_ff,    plen_in;
   logic [3:0]      limit_ff;

   logic            advance;
   logic            take;

   // Decision scratch
   logic [7:0]      ulen;
   logic            emit_valid;
   logic [7:0]      emit_ctrl;
   logic [7:0]      emit_dlen;
   logic            emit_attach;
   logic            accepted;
   logic            deliver;
   lpsf_timer_type  timer;

   // Move the input word on when the result register is free or being drained
   assign advance = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign take = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_item_ff.operation   <= req_bus.operation;
         in_item_ff.rx_primary  <= req_bus.rx_primary;
         in_item_ff.rx_function <= req_bus.rx_function;
         in_item_ff.rx_dfc      <= req_bus.rx_dfc;
         in_item_ff.user_length <= req_bus.user_length;
      end
   end

   // Event decision
   always_comb begin
      ulen = (in_item_ff.user_length > MAX_USER_LENGTH) ? MAX_USER_LENGTH
                                                          : in_item_ff.user_length;
      state_in    = state_ff;
      retry_in    = retry_ff;
      fcb_in      = fcb_ff;
      sreset_in   = sreset_ff;
      sovf_in     = sovf_ff;
      plen_in     = plen_ff;
      emit_valid  = 1'b0;
      emit_ctrl   = 8'h00;
      emit_dlen   = 8'h00;
      emit_attach = 1'b0;
      accepted    = 1'b0;
      deliver     = 1'b0;
      timer       = TMR_KEEP;

      unique case (lpsf_op_type'(in_item_ff.operation))
         OP_SEND_UNCONF: begin
            if (state_ff == ST_UNRESET_IDLE || state_ff == ST_RESET_IDLE) begin
               plen_in     = ulen;
               emit_valid  = 1'b1;
               emit_ctrl   = CTRL_UNCONF_DATA;
               emit_dlen   = ulen;
               emit_attach = 1'b1;
               accepted    = 1'b1;
            end
         end
         OP_SEND_CONF: begin
            if (state_ff == ST_RESET_IDLE) begin
               plen_in     = ulen;
               emit_valid  = 1'b1;
               emit_ctrl   = fcv_control(fcb_ff, CTRL_FC_CFM);
               emit_dlen   = ulen;
               emit_attach = 1'b1;
               retry_in    = 4'd0;
               timer       = TMR_START;
               state_in    = ST_CFM_WAIT;
               accepted    = 1'b1;
            end else if (state_ff == ST_UNRESET_IDLE) begin
               // Link not reset yet: send reset link first, data follows on ack
               plen_in     = ulen;
               emit_valid  = 1'b1;
               emit_ctrl   = CTRL_RESET_LINK;
               retry_in    = 4'd0;
               timer       = TMR_START;
               state_in    = ST_RL_WAIT_DATA;
               accepted    = 1'b1;
            end
         end
         OP_SEND_TEST: begin
            if (state_ff == ST_RESET_IDLE) begin
               emit_valid = 1'b1;
               emit_ctrl  = fcv_control(fcb_ff, CTRL_FC_TEST);
               retry_in   = 4'd0;
               timer      = TMR_START;
               state_in   = ST_TEST_WAIT;
               accepted   = 1'b1;
            end
         end
         OP_TIMEOUT: begin
            if (retry_ff >= limit_ff) begin
               state_in  = ST_UNRESET_IDLE;
               sreset_in = 1'b0;
               sovf_in   = 1'b0;
               retry_in  = 4'd0;
            end
            unique case (state_in)
               ST_RL_WAIT, ST_RL_WAIT_DATA: begin
                  emit_valid = 1'b1;
                  emit_ctrl  = CTRL_RESET_LINK;
               end
               ST_UR_STATUS_WAIT, ST_R_STATUS_WAIT: begin
                  emit_valid = 1'b1;
                  emit_ctrl  = CTRL_STATUS_REQ;
               end
               ST_TEST_WAIT: begin
                  emit_valid = 1'b1;
                  emit_ctrl  = fcv_control(fcb_ff, CTRL_FC_TEST);
               end
               ST_CFM_WAIT: begin
                  emit_valid  = 1'b1;
                  emit_ctrl   = fcv_control(fcb_ff, CTRL_FC_CFM);
                  emit_dlen   = plen_ff;
                  emit_attach = 1'b1;
               end
               default: begin
               end
            endcase
            if (emit_valid) begin
               retry_in = retry_in + 4'd1;
               timer    = TMR_START;
            end else begin
               timer = TMR_STOP;
            end
         end
         OP_FRAME_RX: begin
            if (in_item_ff.rx_primary) begin
               // Frame from a primary: ack all but unconfirmed data, pass user data up
               if (in_item_ff.rx_function == FC_CFM_DATA) begin
                  emit_valid = 1'b1;
                  emit_ctrl  = CTRL_ACK;
                  deliver    = 1'b1;
               end else if (in_item_ff.rx_function == FC_UNCONF_DATA) begin
                  deliver = 1'b1;
               end else begin
                  emit_valid = 1'b1;
                  emit_ctrl  = CTRL_ACK;
               end
            end else begin
               timer = TMR_STOP;
               unique case (state_ff)
                  ST_RL_WAIT: begin
                     if (in_item_ff.rx_function == FC_ACK) begin
                        fcb_in    = 1'b1;
                        sreset_in = 1'b1;
                        state_in  = ST_RESET_IDLE;
                     end else begin
                        sreset_in = 1'b0;
                        state_in  = ST_UNRESET_IDLE;
                     end
                  end
                  ST_RL_WAIT_DATA: begin
                     if (in_item_ff.rx_function == FC_ACK) begin
                        // Reset acked: send the held confirmed data with FCB set
                        fcb_in      = 1'b1;
                        sreset_in   = 1'b1;
                        emit_valid  = 1'b1;
                        emit_ctrl   = fcv_control(1'b1, CTRL_FC_CFM);
                        emit_dlen   = plen_ff;
                        emit_attach = 1'b1;
                        retry_in    = 4'd0;
                        timer       = TMR_START;
                        state_in    = ST_CFM_WAIT;
                     end else begin
                        sreset_in = 1'b0;
                        state_in  = ST_UNRESET_IDLE;
                     end
                  end
                  ST_UR_STATUS_WAIT, ST_R_STATUS_WAIT: begin
                     state_in = (state_ff == ST_UR_STATUS_WAIT) ? ST_UNRESET_IDLE
                                                                : ST_RESET_IDLE;
                     if (in_item_ff.rx_function == FC_LINK_STATUS) begin
                        sovf_in = in_item_ff.rx_dfc;
                     end
                  end
                  ST_TEST_WAIT: begin
                     if (in_item_ff.rx_function == FC_ACK) begin
                        fcb_in   = !fcb_ff;
                        state_in = ST_RESET_IDLE;
                     end else begin
                        sreset_in = 1'b0;
                        state_in  = ST_UNRESET_IDLE;
                     end
                  end
                  ST_CFM_WAIT: begin
                     if (in_item_ff.rx_function == FC_ACK) begin
                        fcb_in   = !fcb_ff;
                        state_in = ST_RESET_IDLE;
                     end else if (in_item_ff.rx_function == FC_NACK) begin
                        sreset_in = 1'b0;
                        if (in_item_ff.rx_dfc) begin
                           // Secondary overflowed: drop to unreset idle
                           sovf_in  = 1'b1;
                           state_in = ST_UNRESET_IDLE;
                        end else begin
                           retry_in   = 4'd0;
                           emit_valid = 1'b1;
                           emit_ctrl  = CTRL_RESET_LINK;
                           timer      = TMR_START;
                           state_in   = ST_RL_WAIT_DATA;
                        end
                     end else begin
                        sreset_in = 1'b0;
                        state_in  = ST_UNRESET_IDLE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
         end
      endcase

      out_in.accepted             = accepted;
      out_in.send_valid           = emit_valid;
      out_in.send_control         = emit_ctrl;
      out_in.send_length          = HDR_LENGTH + emit_dlen;
      out_in.attach_userdata      = emit_attach;
      out_in.deliver_userdata     = deliver;
      out_in.timer_command        = timer;
      out_in.link_state_out       = state_code(state_in);
      out_in.station_reset_out    = sreset_in;
      out_in.station_overflow_out = sovf_in;
   end

   // Commit link state together with the result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_UNRESET_IDLE;
         retry_ff  <= 4'd0;
         fcb_ff    <= 1'b0;
         sreset_ff <= 1'b0;
         sovf_ff   <= 1'b0;
         plen_ff   <= 8'd0;
      end else if (advance) begin
         state_ff  <= state_in;
         retry_ff  <= retry_in;
         fcb_ff    <= fcb_in;
         sreset_ff <= sreset_in;
         sovf_ff   <= sovf_in;
         plen_ff   <= plen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= RETRY_LIMIT_RESET;
      end else if (csr_bus.valid) begin
         limit_ff <= csr_bus.data;
      end
   end

   // Result register: load on advance, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_bus.valid                = out_valid_ff;
   assign rsp_bus.accepted             = out_ff.accepted;
   assign rsp_bus.send_valid           = out_ff.send_valid;
   assign rsp_bus.send_control         = out_ff.send_control;
   assign rsp_bus.send_length          = out_ff.send_length;
   assign rsp_bus.attach_userdata      = out_ff.attach_userdata;
   assign rsp_bus.deliver_userdata     = out_ff.deliver_userdata;
   assign rsp_bus.timer_command        = out_ff.timer_command;
   assign rsp_bus.link_state_out       = out_ff.link_state_out;
   assign rsp_bus.station_reset_out    = out_ff.station_reset_out;
   assign rsp_bus.station_overflow_out = out_ff.station_overflow_out;

endmodule

[hdl/lpsf_checker.sv]
// ----------------------------------------------------------------------------
// lpsf_checker
// Port-level checks on the link primary station result channel.
// ----------------------------------------------------------------------------
module lpsf_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       send_valid,
   input logic [7:0] send_control,
   input logic [7:0] send_length,
   input logic       attach_userdata,
   input logic [1:0] timer_command,
   input logic [2:0] link_state_out
);
   import lpsf_pkg::*;

   // Stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(send_control)
         && $stable(send_length) && $stable(link_state_out))
      else $error("result word changed while stalled");

   // Pipeline empties on reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A timer start always goes with a frame
   a_start_sends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && timer_command == TMR_START |-> send_valid)
      else $error("timer started without a frame");

   // No frame means an empty header slot
   a_no_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !send_valid |-> send_control == 8'h00
         && send_length == HDR_LENGTH && !attach_userdata)
      else $error("frame fields set without a frame");

endmodule

bind link_primary_station_fsm lpsf_checker u_lpsf_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .send_valid      (rsp_bus.send_valid),
   .send_control    (rsp_bus.send_control),
   .send_length     (rsp_bus.send_length),
   .attach_userdata (rsp_bus.attach_userdata),
   .timer_command   (rsp_bus.timer_command),
   .link_state_out  (rsp_bus.link_state_out)
);
